// ===== design/rse_pkg.sv =====
// Package for the RGB Sobel edge threshold block: transfer payload types,
// register codes, gray conversion constants and window sum helper.
// No dependencies.
`default_nettype none

package rse_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       frame_last;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic active;
    logic flushing;
    logic end_row;
    logic c_ge1;
    logic c_ge2;
  } ctl_t;

  localparam logic [17:0] GRAY_COEF_R = 18'd299;
  localparam logic [17:0] GRAY_COEF_G = 18'd587;
  localparam logic [17:0] GRAY_COEF_B = 18'd114;
  localparam logic [36:0] GRAY_RECIP  = 37'd268436;
  localparam int          GRAY_SHIFT  = 28;

  localparam logic [10:0] WIDTH_RESET  = 11'd1024;
  localparam logic [15:0] HEIGHT_RESET = 16'd1024;
  localparam logic [10:0] THR_RESET    = 11'd200;
  localparam logic [21:0] THR_SQ_RESET = 22'd40000;

  localparam logic [7:0] EDGE_ON  = 8'd255;
  localparam logic [7:0] EDGE_OFF = 8'd0;

  localparam int FIFO_DEPTH = 8;

  function automatic logic [9:0] wsum(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

endpackage

`default_nettype wire

// ===== design/rse_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module rse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/rgb_sobel_edge_threshold.sv =====
// Streaming RGB to gray Sobel edge detector with a magnitude threshold.
// Depends on rse_pkg and rse_ram (two gray line memories).
//
// Usage: RGB pixels arrive in raster order on the in_ channel, one transfer
// per clock when not stalled. Edge results (255 or 0) leave on the out_
// channel in raster order, one row behind the input; frame_last marks the
// last result of a frame, which is produced while the next frame's first row
// is taken in. A pixel at the end of a row yields two results, the first of
// a row none unless it also ends it, others one. Throughput is one pixel
// per clock when not stalled, set by the single read and single write per
// cycle of each line memory; the output side sustains one result per clock
// while out_stall is low. When the receiver stalls, results collect in an
// eight-entry queue; once it holds more than six, the whole pipeline freezes
// and in_stall rises. Reset clears counters, the window, the queue and the
// registers to their defaults (width 1024, height 1024, threshold 200). Line
// memories need no clearing: a row is always written before it is read.
// Configuration goes through the APB-style port while no pixel is in flight:
// the user must keep to this, as the block itself does not enforce it.
`default_nettype none

module rgb_sobel_edge_threshold #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rse_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rse_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rse_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int FPW  = $clog2(FIFO_DEPTH);

  logic [10:0] width_r;
  logic [15:0] height_r;
  logic [10:0] thr_r;
  logic [21:0] thr_sq_r;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      thr_r    <= THR_RESET;
      thr_sq_r <= THR_SQ_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:    width_r <= pwdata[10:0];
        REG_IMAGE_HEIGHT:   height_r <= pwdata[15:0];
        REG_EDGE_THRESHOLD: begin
          thr_r    <= pwdata[10:0];
          thr_sq_r <= 22'(pwdata[10:0]) * 22'(pwdata[10:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:    prdata = {21'd0, width_r};
      REG_IMAGE_HEIGHT:   prdata = {16'd0, height_r};
      REG_EDGE_THRESHOLD: prdata = {21'd0, thr_r};
      default:            prdata = 32'd0;
    endcase
  end

  // Pipeline control and output queue occupancy.
  logic [FPW:0] fifo_cnt_r, fifo_cnt_nxt;
  logic         adv, accept;

  assign adv      = fifo_cnt_r <= (FPW+1)'(FIFO_DEPTH - 2);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Frame position counters.
  logic [CW-1:0]   col_r, col_nxt;
  logic [15:0]     row_r, row_nxt;
  logic            slot_r, flush_pending_r, flush_single_r;
  logic [CMPW-1:0] w_ext, w_eff;
  logic [15:0]     h_eff;
  logic            end_row, last_row, flushing;

  assign w_ext    = CMPW'(width_r);
  assign w_eff    = (width_r == 11'd0) ? CMPW'(1) :
                    (w_ext > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : w_ext;
  assign h_eff    = (height_r == 16'd0) ? 16'd1 : height_r;
  assign end_row  = (CMPW'(col_r) + CMPW'(1)) >= w_eff;
  assign last_row = ({1'b0, row_r} + 17'd1) >= {1'b0, h_eff};
  assign flushing = row_r == 16'd0;
  assign col_nxt  = end_row ? '0 : col_r + CW'(1);
  assign row_nxt  = last_row ? 16'd0 : row_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r           <= '0;
      row_r           <= '0;
      slot_r          <= 1'b0;
      flush_pending_r <= 1'b0;
      flush_single_r  <= 1'b0;
    end else if (accept) begin
      col_r <= col_nxt;
      if (end_row) begin
        row_r  <= row_nxt;
        slot_r <= !slot_r;
        if (last_row) begin
          flush_pending_r <= 1'b1;
          flush_single_r  <= h_eff == 16'd1;
        end else if (flushing) begin
          flush_pending_r <= 1'b0;
        end
      end
    end
  end

  // Stage 1: gray sum and line memory read.
  logic          v1_r, slot1_r, top_prev1_r;
  logic [17:0]   sum1_r;
  logic [CW-1:0] c1_r;
  ctl_t          ctl1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum1_r <= 18'(in_data.red) * GRAY_COEF_R + 18'(in_data.green) * GRAY_COEF_G
              + 18'(in_data.blue) * GRAY_COEF_B;
      c1_r           <= col_r;
      slot1_r        <= slot_r;
      top_prev1_r    <= flushing ? flush_single_r : (row_r == 16'd1);
      ctl1_r.active   <= !flushing || flush_pending_r;
      ctl1_r.flushing <= flushing;
      ctl1_r.end_row  <= end_row;
      ctl1_r.c_ge1    <= col_r != '0;
      ctl1_r.c_ge2    <= col_r > CW'(1);
    end
  end

  // Stage 1 -> 2: gray, window update and line memory write.
  logic [36:0] gray_prod;
  logic [7:0]  gray;
  logic [7:0]  ram0_rdata, ram1_rdata, ram0_q, ram1_q;
  logic [7:0]  old_row, prev_row, top_px, mid_px, bot_px;
  logic        we0, we1;
  logic        fwd_hit_r, fwd_ram_r;
  logic [7:0]  fwd_data_r;

  assign gray_prod = 37'(sum1_r) * GRAY_RECIP;
  assign gray      = gray_prod[GRAY_SHIFT +: 8];
  assign we0       = adv && v1_r && !slot1_r;
  assign we1       = adv && v1_r && slot1_r;

  rse_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk  (clk),
    .we   (we0),
    .waddr(c1_r),
    .wdata(gray),
    .re   (accept),
    .raddr(col_r),
    .rdata(ram0_rdata)
  );

  rse_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk  (clk),
    .we   (we1),
    .waddr(c1_r),
    .wdata(gray),
    .re   (accept),
    .raddr(col_r),
    .rdata(ram1_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (adv) begin
      fwd_hit_r <= v1_r && accept && (c1_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_ram_r  <= slot1_r;
      fwd_data_r <= gray;
    end
  end

  assign ram0_q   = (fwd_hit_r && !fwd_ram_r) ? fwd_data_r : ram0_rdata;
  assign ram1_q   = (fwd_hit_r && fwd_ram_r) ? fwd_data_r : ram1_rdata;
  assign old_row  = slot1_r ? ram1_q : ram0_q;
  assign prev_row = slot1_r ? ram0_q : ram1_q;
  assign top_px   = top_prev1_r ? prev_row : old_row;
  assign mid_px   = prev_row;
  assign bot_px   = ctl1_r.flushing ? prev_row : gray;

  logic [7:0] win_r [3][3];
  logic       v2_r;
  ctl_t       ctl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= 8'd0;
        end
      end
    end else if (adv && v1_r) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= top_px;
      win_r[1][2] <= mid_px;
      win_r[2][2] <= bot_px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl2_r <= ctl1_r;
    end
  end

  // Stage 2: gradients for the two candidate results.
  logic [9:0]         cs [3];
  logic [1:0]         lc1, lc2;
  logic signed [11:0] gx1, gy1, gx2, gy2;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cs[j] = wsum(win_r[0][j], win_r[1][j], win_r[2][j]);
    end
    lc1 = ctl2_r.c_ge2 ? 2'd0 : 2'd1;
    lc2 = ctl2_r.c_ge1 ? 2'd1 : 2'd2;
    gx1 = $signed({2'b00, cs[2]}) - $signed({2'b00, cs[lc1]});
    gy1 = $signed({2'b00, wsum(win_r[2][lc1], win_r[2][1], win_r[2][2])})
        - $signed({2'b00, wsum(win_r[0][lc1], win_r[0][1], win_r[0][2])});
    gx2 = $signed({2'b00, cs[2]}) - $signed({2'b00, cs[lc2]});
    gy2 = $signed({2'b00, wsum(win_r[2][lc2], win_r[2][2], win_r[2][2])})
        - $signed({2'b00, wsum(win_r[0][lc2], win_r[0][2], win_r[0][2])});
  end

  logic               v3_r;
  ctl_t               ctl3_r;
  logic signed [11:0] gx1_r, gy1_r, gx2_r, gy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl3_r <= ctl2_r;
      gx1_r  <= gx1;
      gy1_r  <= gy1;
      gx2_r  <= gx2;
      gy2_r  <= gy2;
    end
  end

  // Stage 3: squared magnitudes.
  logic signed [23:0] sqx1, sqy1, sqx2, sqy2;
  logic [21:0]        mag1, mag2;

  assign sqx1 = gx1_r * gx1_r;
  assign sqy1 = gy1_r * gy1_r;
  assign sqx2 = gx2_r * gx2_r;
  assign sqy2 = gy2_r * gy2_r;
  assign mag1 = {1'b0, sqx1[20:0]} + {1'b0, sqy1[20:0]};
  assign mag2 = {1'b0, sqx2[20:0]} + {1'b0, sqy2[20:0]};

  logic        v4_r;
  ctl_t        ctl4_r;
  logic [21:0] mag1_r, mag2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl4_r <= ctl3_r;
      mag1_r <= mag1;
      mag2_r <= mag2;
    end
  end

  // Stage 4: threshold and queue write.
  logic            push1, push2, pop;
  logic [1:0]      pushes;
  out_item_t       res1, res2;
  out_item_t       fifo_mem [FIFO_DEPTH];
  logic [FPW-1:0]  wr_ptr_r, rd_ptr_r;

  assign push1 = adv && v4_r && ctl4_r.active && ctl4_r.c_ge1;
  assign push2 = adv && v4_r && ctl4_r.active && ctl4_r.end_row;
  assign pushes = {1'b0, push1} + {1'b0, push2};
  assign res1.edge_value = (mag1_r >= thr_sq_r) ? EDGE_ON : EDGE_OFF;
  assign res1.frame_last = 1'b0;
  assign res2.edge_value = (mag2_r >= thr_sq_r) ? EDGE_ON : EDGE_OFF;
  assign res2.frame_last = ctl4_r.flushing;

  assign out_valid    = fifo_cnt_r != '0;
  assign out_data     = fifo_mem[rd_ptr_r];
  assign pop          = out_valid && !out_stall;
  assign fifo_cnt_nxt = fifo_cnt_r + (FPW+1)'(pushes) - (FPW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push1) begin
      fifo_mem[wr_ptr_r] <= res1;
    end
    if (push2) begin
      fifo_mem[push1 ? wr_ptr_r + FPW'(1) : wr_ptr_r] <= res2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_cnt_r <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      wr_ptr_r   <= wr_ptr_r + FPW'(pushes);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FPW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= (FPW+1)'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> v1_r)
    else $error("forwarding hit without an item in stage one");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted transfer did not enter the pipeline");

  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && v4_r) |=> (v4_r && $stable(mag1_r) && $stable(mag2_r)))
    else $error("last stage changed while the pipeline was frozen");
`endif

endmodule

`default_nettype wire
